>>> src/assert_macros.svh
// Assertion macros shared by the vector mask register unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define VMR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define VMR_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/vmr_pkg.sv
// Types, codes and helper functions of the vector mask register unit.
package vmr_pkg;

    typedef enum logic [3:0] {
        OP_TEST   = 4'd0,
        OP_COMPL  = 4'd1,
        OP_LZ     = 4'd2,
        OP_ONES   = 4'd3,
        OP_READ   = 4'd4,
        OP_LOAD   = 4'd5,
        OP_LOADC  = 4'd6,
        OP_AND    = 4'd7,
        OP_OR     = 4'd8,
        OP_XOR    = 4'd9,
        OP_STORE  = 4'd10,
        OP_SETCNT = 4'd11
    } op_t;

    localparam logic [1:0] CC_ZERO     = 2'd0;
    localparam logic [1:0] CC_MIXED    = 2'd1;
    localparam logic [1:0] CC_ONES     = 2'd3;
    localparam logic [1:0] CC_NEG      = 2'd1;
    localparam logic [1:0] CC_OVER     = 2'd2;
    localparam logic [1:0] CC_IN_RANGE = 2'd3;

    localparam int MAX_RESULTS = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] TRIM_SEED = 16'h7F00;
    localparam logic [15:0] BYTE_MASK = 16'h00FF;

    typedef struct packed {
        logic [3:0]         kind;
        logic [3:0]         byte_index;
        logic [7:0]         operand_byte;
        logic signed [31:0] count_value;
    } req_t;

    typedef struct packed {
        logic [1:0] cond_code;
        logic [7:0] bit_count;
        logic [7:0] mask_byte;
        logic       last;
    } rsp_t;

    typedef struct packed {
        op_t                op;
        logic [3:0]         byte_index;
        logic [7:0]         operand_byte;
        logic signed [31:0] count_value;
        logic [1:0]         set_cc;
    } cmd_t;

    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

    function automatic logic [3:0] clz8(input logic [7:0] b);
        logic [3:0] n;
        logic       hit;
        n   = '0;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!hit)
            begin
                if (b[i])
                    hit = 1'b1;
                else
                    n = n + 4'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [7:0] part_mask(input logic [2:0] r);
        logic [15:0] s;
        s = (TRIM_SEED >> r) & BYTE_MASK;
        return s[7:0];
    endfunction

endpackage

>>> src/vmr_ram.sv
// Generic simple dual-port RAM with registered read.
module vmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 17
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/vmr_front.sv
// Front end: accepts requests, drops undefined kinds and classifies set-count values.
module vmr_front
    import vmr_pkg::*;
#(
    parameter int SECTION_BITS = 128
) (
    input  logic start,
    input  logic busy,
    input  req_t request,
    output logic push,
    output cmd_t cmd
);

    logic known;

    always_comb
    begin
        unique case (request.kind) inside
            OP_TEST, OP_COMPL, OP_LZ, OP_ONES, OP_READ, OP_LOAD, OP_LOADC,
            OP_AND, OP_OR, OP_XOR, OP_STORE, OP_SETCNT: known = 1'b1;
            default:                                    known = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd.op           = op_t'(request.kind);
        cmd.byte_index   = request.byte_index;
        cmd.operand_byte = request.operand_byte;
        cmd.count_value  = request.count_value;
        if (request.count_value == 32'sd0)
            cmd.set_cc = CC_ZERO;
        else if (request.count_value[31])
            cmd.set_cc = CC_NEG;
        else if ($unsigned(request.count_value) > 32'(SECTION_BITS))
            cmd.set_cc = CC_OVER;
        else
            cmd.set_cc = CC_IN_RANGE;
    end

    assign push = start && !busy && known;

endmodule

>>> src/vmr_queue.sv
// Short command queue between the front end and the back end.
module vmr_queue
    import vmr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    `include "assert_macros.svh"

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QUEUE_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QUEUE_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = QUEUE_CW'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = QUEUE_CW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    `VMR_NEVER(q_underflow, pop && empty, "queue popped while empty")
    `VMR_NEVER(q_overflow, push && full && !pop, "queue pushed while full")
    `VMR_NEVER(q_count_range, count_reg > QUEUE_CW'(QUEUE_DEPTH), "queue count above depth")

endmodule

>>> src/vmr_back.sv
// Back end: mask state, byte sweeps over the mask RAM and result generation.
module vmr_back
    import vmr_pkg::*;
#(
    parameter int SECTION_BITS = 128
) (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t head,
    input  logic q_empty,
    output logic pop,
    output logic strobe,
    output rsp_t rsp
);

    `include "assert_macros.svh"

    localparam int SLOTS = SECTION_BITS / 8 + 1;
    localparam int AW    = $clog2(SLOTS);
    localparam int NW    = $clog2(SECTION_BITS + 1);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SWEEP   = 5'b00010,
        ST_BYTE_EX = 5'b00100,
        ST_TRIM_RD = 5'b01000,
        ST_TRIM_EX = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [NW-1:0]    ones_reg, ones_next;
    logic [NW-1:0]    lz_reg, lz_next;
    logic             found_reg, found_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic             rd_valid_reg;
    logic             strobe_reg, strobe_next;
    rsp_t             rsp_reg, rsp_next;

    logic          rd_en, wr_en, clear_above;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    wr_data, ram_q, rdata;
    logic [AW-1:0] top, idx;
    logic [2:0]    rem;
    logic [7:0]    masked, byte_val;
    logic [NW-1:0] ones_sum, lz_val, lz_final;
    logic          lz_hit;
    logic [1:0]    uni_cc;

    function automatic logic [7:0] active_bits(input logic [AW-1:0] j, input logic [AW-1:0] t,
                                               input logic [2:0] r);
        logic [7:0] m;
        if (j < t)
            m = 8'hFF;
        else if (j == t)
            m = part_mask(r);
        else
            m = 8'h00;
        return m;
    endfunction

    vmr_ram #(
        .WIDTH(8),
        .DEPTH(SLOTS)
    ) u_mask_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(ram_q)
    );

    assign top   = AW'(n_reg >> 3);
    assign rem   = n_reg[2:0];
    assign idx   = AW'(cmd_reg.byte_index);
    assign rdata = rd_valid_reg ? ram_q : 8'h00;

    assign masked   = rdata & active_bits(ptr_reg, top, rem);
    assign ones_sum = NW'(ones_reg + NW'(popcount8(masked)));
    assign lz_hit   = !found_reg && (masked != 8'h00);
    assign lz_val   = NW'(NW'({ptr_reg, 3'b000}) + NW'(clz8(masked)));
    assign lz_final = found_reg ? lz_reg : (lz_hit ? lz_val : n_reg);

    always_comb
    begin
        if (ones_sum == '0)
            uni_cc = CC_ZERO;
        else if (ones_sum == n_reg)
            uni_cc = CC_ONES;
        else
            uni_cc = CC_MIXED;
    end

    always_comb
    begin
        case (cmd_reg.op)
            OP_LOAD:  byte_val = cmd_reg.operand_byte;
            OP_LOADC: byte_val = ~cmd_reg.operand_byte;
            OP_AND:   byte_val = rdata & cmd_reg.operand_byte;
            OP_OR:    byte_val = rdata | cmd_reg.operand_byte;
            default:  byte_val = rdata ^ cmd_reg.operand_byte;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        n_next      = n_reg;
        ptr_next    = ptr_reg;
        ones_next   = ones_reg;
        lz_next     = lz_reg;
        found_next  = found_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        clear_above = 1'b0;
        strobe_next = 1'b0;
        rsp_next    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    unique case (head.op) inside
                        OP_READ:
                        begin
                            strobe_next        = 1'b1;
                            rsp_next.bit_count = 8'(n_reg);
                            rsp_next.last      = 1'b1;
                        end
                        OP_SETCNT:
                        begin
                            if (head.set_cc == CC_IN_RANGE)
                                n_next = NW'(head.count_value);
                            else if (head.set_cc == CC_OVER)
                                n_next = NW'(SECTION_BITS);
                            else
                                n_next = '0;
                            strobe_next        = 1'b1;
                            rsp_next.cond_code = head.set_cc;
                            rsp_next.last      = 1'b1;
                        end
                        OP_TEST, OP_LZ, OP_ONES, OP_COMPL, OP_STORE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            ptr_next   = '0;
                            ones_next  = '0;
                            lz_next    = '0;
                            found_next = 1'b0;
                            state_next = ST_SWEEP;
                        end
                        OP_LOAD, OP_LOADC, OP_AND, OP_OR, OP_XOR:
                        begin
                            rd_en = 1'b1;
                            if (32'(head.byte_index) <= 32'(top))
                            begin
                                rd_addr    = AW'(head.byte_index);
                                state_next = ST_BYTE_EX;
                            end
                            else
                            begin
                                rd_addr    = top;
                                state_next = ST_TRIM_EX;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                ones_next = ones_sum;
                if (lz_hit)
                begin
                    found_next = 1'b1;
                    lz_next    = lz_val;
                end
                if (cmd_reg.op == OP_COMPL)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ptr_reg;
                    wr_data = (rdata ^ 8'hFF) & active_bits(ptr_reg, top, rem);
                end
                if (cmd_reg.op == OP_STORE)
                begin
                    if (ptr_reg == top)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ptr_reg;
                        wr_data = masked;
                    end
                    if (32'(ptr_reg) < MAX_RESULTS)
                    begin
                        strobe_next        = 1'b1;
                        rsp_next.mask_byte = masked;
                        rsp_next.last      = (ptr_reg == top)
                                             || (32'(ptr_reg) == MAX_RESULTS - 1);
                    end
                end
                if (ptr_reg == top)
                begin
                    state_next = ST_IDLE;
                    case (cmd_reg.op) inside
                        OP_TEST:
                        begin
                            strobe_next        = 1'b1;
                            rsp_next.cond_code = uni_cc;
                            rsp_next.last      = 1'b1;
                        end
                        OP_LZ:
                        begin
                            strobe_next        = 1'b1;
                            rsp_next.cond_code = uni_cc;
                            rsp_next.bit_count = 8'(lz_final);
                            rsp_next.last      = 1'b1;
                        end
                        OP_ONES:
                        begin
                            strobe_next        = 1'b1;
                            rsp_next.cond_code = uni_cc;
                            rsp_next.bit_count = 8'(ones_sum);
                            rsp_next.last      = 1'b1;
                        end
                        OP_COMPL:
                        begin
                            clear_above   = 1'b1;
                            strobe_next   = 1'b1;
                            rsp_next.last = 1'b1;
                        end
                        default:
                        begin
                            clear_above = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(ptr_reg + 1'b1);
                    ptr_next = AW'(ptr_reg + 1'b1);
                end
            end
            ST_BYTE_EX:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx;
                wr_data    = byte_val & active_bits(idx, top, rem);
                state_next = ST_TRIM_RD;
            end
            ST_TRIM_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = top;
                state_next = ST_TRIM_EX;
            end
            ST_TRIM_EX:
            begin
                wr_en         = 1'b1;
                wr_addr       = top;
                wr_data       = rdata & part_mask(rem);
                clear_above   = 1'b1;
                strobe_next   = 1'b1;
                rsp_next.last = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
            valid_next[wr_addr] = 1'b1;
        if (clear_above)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                if (32'(j) > 32'(top))
                    valid_next[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            n_reg        <= '0;
            ptr_reg      <= '0;
            found_reg    <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            ptr_reg    <= ptr_next;
            found_reg  <= found_next;
            valid_reg  <= valid_next;
            strobe_reg <= strobe_next;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        ones_reg <= ones_next;
        lz_reg   <= lz_next;
        rsp_reg  <= rsp_next;
    end

    assign strobe = strobe_reg;
    assign rsp    = rsp_reg;

    `VMR_NEVER(count_range, n_reg > NW'(SECTION_BITS), "vector count above section size")
    `VMR_ASSERT(write_in_range, wr_en |-> (32'(wr_addr) <= 32'(top)),
                "mask write above the partial byte")
    `VMR_ASSERT(state_onehot, $onehot(state_reg), "back end state not one-hot")

endmodule

>>> src/vector_mask_register_unit.sv
// Top level of the vector mask register unit.
// Request channel: a request is taken at a rising edge with start high and busy low.
// Kinds 12 to 15 are taken and dropped without a result. Busy is high while the
// two-entry command queue between the front end and the back end is full.
// Result channel: result_strobe marks each result for exactly one cycle; the
// receiver takes it at that edge and cannot hold results off.
// How each kind reaches its result, with the back end idle:
//   read count and set count: answered straight from the idle state;
//   test, complement, leading zeros, count ones: a sweep over the mask, one mask byte
//   per cycle from the mask RAM;
//   store: one byte per cycle from the first mask byte on, the last one being
//   byte min(n/8, 15);
//   per-byte load and logical kinds: read, write, read and trim the partial
//   byte, or only read and trim it when byte_index lies above the count.
// The back end works on one request at a time and takes the next one from the queue
// only once it is back in the idle state.
// Reset clears the vector count, the queue and the per-byte valid bits of the mask,
// so the mask reads as all zeros at once; no clearing pass is needed.
module vector_mask_register_unit
    import vmr_pkg::*;
#(
    parameter int SECTION_BITS = 128
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic result_strobe,
    output rsp_t result
);

    logic push, pop, q_empty, q_full;
    cmd_t push_cmd, head;

    vmr_front #(
        .SECTION_BITS(SECTION_BITS)
    ) u_front (
        .start  (start),
        .busy   (q_full),
        .request(request),
        .push   (push),
        .cmd    (push_cmd)
    );

    vmr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head    (head),
        .empty   (q_empty),
        .full    (q_full)
    );

    vmr_back #(
        .SECTION_BITS(SECTION_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_empty(q_empty),
        .pop    (pop),
        .strobe (result_strobe),
        .rsp    (result)
    );

    assign busy = q_full;

endmodule
